// ===== hw/rtl/psch_pkg.sv =====
// ----------------------------------------------------------------------------
// psch_pkg
// Shared types and constants for the preemptive priority scheduler core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package psch_pkg;

  localparam int SLOTS_DEF = 16;
  localparam int TIME_W    = 24;
  localparam int TASK_W    = 16;
  localparam int PRIO_W    = 8;
  localparam int ID_W      = 5;

  localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};

  // mode codes of an input word
  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_TICK  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  typedef struct packed {
    logic [1:0]               mode;
    logic [TASK_W-1:0]        arrival_time;
    logic [TASK_W-1:0]        burst_time;
    logic signed [PRIO_W-1:0] priority_req;
  } in_word_t;

  typedef struct packed {
    logic [TIME_W-1:0] time_now;
    logic              ran_valid;
    logic [ID_W-1:0]   ran_id;
    logic              finished;
    logic [TIME_W-1:0] finish_time;
    logic [TIME_W-1:0] turnaround;
    logic [TIME_W-1:0] waiting;
    logic              all_done;
  } out_word_t;

  typedef enum logic {
    ST_IDLE,
    ST_COMMIT
  } state_t;

  typedef struct packed {
    logic load_en;
    logic clear_en;
    logic pick_en;
    logic commit_en;
  } cmd_t;

  typedef struct packed {
    logic table_full;
  } stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/psch_ctrl.sv =====
// ----------------------------------------------------------------------------
// psch_ctrl
// Controller: takes input words and sequences load, clear, pick and commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psch_ctrl (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            start,
  input  wire logic [1:0]      mode,
  input  wire psch_pkg::stat_t stat,
  output logic                 busy,
  output psch_pkg::cmd_t       cmd
);

  psch_pkg::state_t state_r;
  psch_pkg::state_t state_nxt;
  logic             accept;

  assign accept = start && (state_r == psch_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= psch_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      psch_pkg::ST_IDLE: begin
        if (accept && (mode == psch_pkg::MODE_TICK)) begin
          state_nxt = psch_pkg::ST_COMMIT;
        end
      end
      psch_pkg::ST_COMMIT: begin
        state_nxt = psch_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = psch_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    busy          = 1'b0;
    cmd.load_en   = 1'b0;
    cmd.clear_en  = 1'b0;
    cmd.pick_en   = 1'b0;
    cmd.commit_en = 1'b0;
    unique case (state_r)
      psch_pkg::ST_IDLE: begin
        cmd.load_en  = accept && (mode == psch_pkg::MODE_LOAD) && !stat.table_full;
        cmd.clear_en = accept && (mode == psch_pkg::MODE_CLEAR);
        cmd.pick_en  = accept && (mode == psch_pkg::MODE_TICK);
      end
      psch_pkg::ST_COMMIT: begin
        busy          = 1'b1;
        cmd.commit_en = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

  a_pick_then_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pick_en |=> cmd.commit_en)
    else $error("pick not followed by commit");

  a_single_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_en |=> !cmd.commit_en)
    else $error("commit lasted more than one cycle");

  a_one_command: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load_en, cmd.clear_en, cmd.pick_en, cmd.commit_en}))
    else $error("more than one command at once");

endmodule

`default_nettype wire

// ===== hw/rtl/psch_dp.sv =====
// ----------------------------------------------------------------------------
// psch_dp
// Datapath: task table, time counter, priority comparator tree and results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module psch_dp #(
  parameter int SLOTS = psch_pkg::SLOTS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire psch_pkg::cmd_t      cmd,
  input  wire psch_pkg::in_word_t  in_word,
  output psch_pkg::stat_t          stat,
  output logic                     out_strobe,
  output psch_pkg::out_word_t      out_word
);

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int LEAVES = 1 << IDX_W;
  localparam int TW     = psch_pkg::TIME_W;
  localparam int KW     = psch_pkg::TASK_W;

  typedef struct packed {
    logic                               vld;
    logic signed [psch_pkg::PRIO_W-1:0] prio;
    logic [KW-1:0]                      arr;
    logic [IDX_W-1:0]                   idx;
  } node_t;

  logic [KW-1:0]                      arrival_r [SLOTS];
  logic [KW-1:0]                      burst_r   [SLOTS];
  logic [KW-1:0]                      remain_r  [SLOTS];
  logic signed [psch_pkg::PRIO_W-1:0] prio_r    [SLOTS];

  logic [CNT_W-1:0]    count_r;
  logic [TW-1:0]       time_r;
  logic                pick_vld_r;
  logic [IDX_W-1:0]    pick_idx_r;
  logic                out_strobe_r;
  psch_pkg::out_word_t out_word_r;
  psch_pkg::out_word_t out_nxt;

  node_t         node [1:2*LEAVES-1];
  logic [TW-1:0] time_inc;
  logic [KW-1:0] arr_p;
  logic [KW-1:0] burst_p;
  logic [KW-1:0] remain_p;
  logic [TW-1:0] tat;
  logic          fin;
  logic          done;

  function automatic node_t better(input node_t l, input node_t r);
    logic take_r;
    take_r = r.vld && (!l.vld || (r.prio > l.prio) ||
                       ((r.prio == l.prio) && (r.arr < l.arr)));
    return take_r ? r : l;
  endfunction

  assign stat.table_full = (count_r == CNT_W'(SLOTS));

  // comparator tree over all slots, lower slot wins a full tie
  always_comb begin
    for (int k = 0; k < LEAVES; k++) begin
      node[LEAVES+k] = '0;
      if (k < SLOTS) begin
        node[LEAVES+k].vld  = (CNT_W'(k) < count_r) &&
                              ({{(TW-KW){1'b0}}, arrival_r[k]} <= time_r) &&
                              (remain_r[k] != '0);
        node[LEAVES+k].prio = prio_r[k];
        node[LEAVES+k].arr  = arrival_r[k];
        node[LEAVES+k].idx  = IDX_W'(k);
      end
    end
    for (int k = LEAVES - 1; k >= 1; k--) begin
      node[k] = better(node[2*k], node[2*k+1]);
    end
  end

  assign time_inc = (time_r == psch_pkg::TIME_MAX) ? time_r : time_r + TW'(1);
  assign arr_p    = arrival_r[pick_idx_r];
  assign burst_p  = burst_r[pick_idx_r];
  assign remain_p = remain_r[pick_idx_r];
  assign fin      = pick_vld_r && (remain_p == KW'(1));
  assign tat      = time_inc - {{(TW-KW){1'b0}}, arr_p};

  always_comb begin
    logic [KW-1:0] rem_after;
    done = 1'b1;
    for (int k = 0; k < SLOTS; k++) begin
      rem_after = remain_r[k];
      if (pick_vld_r && (pick_idx_r == IDX_W'(k))) begin
        rem_after = remain_r[k] - KW'(1);
      end
      if ((CNT_W'(k) < count_r) && (rem_after != '0)) begin
        done = 1'b0;
      end
    end
  end

  always_comb begin
    out_nxt             = '0;
    out_nxt.time_now    = time_inc;
    out_nxt.ran_valid   = pick_vld_r;
    out_nxt.ran_id      = pick_vld_r ? psch_pkg::ID_W'(32'(pick_idx_r) + 32'd1) : '0;
    out_nxt.finished    = fin;
    out_nxt.all_done    = done;
    if (fin) begin
      out_nxt.finish_time = time_inc;
      out_nxt.turnaround  = tat;
      out_nxt.waiting     = (tat >= {{(TW-KW){1'b0}}, burst_p}) ?
                            tat - {{(TW-KW){1'b0}}, burst_p} : '0;
    end
  end

  // task table, no reset: entries at or above the fill count are never used
  always_ff @(posedge clk) begin
    if (cmd.load_en) begin
      arrival_r[count_r[IDX_W-1:0]] <= in_word.arrival_time;
      burst_r[count_r[IDX_W-1:0]]   <= in_word.burst_time;
      remain_r[count_r[IDX_W-1:0]]  <= in_word.burst_time;
      prio_r[count_r[IDX_W-1:0]]    <= in_word.priority_req;
    end else if (cmd.commit_en && pick_vld_r) begin
      remain_r[pick_idx_r] <= remain_p - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      time_r       <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.commit_en;
      if (cmd.clear_en) begin
        count_r <= '0;
        time_r  <= '0;
      end else begin
        if (cmd.load_en) begin
          count_r <= count_r + CNT_W'(1);
        end
        if (cmd.commit_en) begin
          time_r <= time_inc;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pick_en) begin
      pick_vld_r <= node[1].vld;
      pick_idx_r <= node[1].idx;
    end
    if (cmd.commit_en) begin
      out_word_r <= out_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

  a_commit_strobes: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit_en |=> out_strobe_r)
    else $error("commit gave no result word");

  a_finish_ran: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe_r && out_word_r.finished) |-> out_word_r.ran_valid)
    else $error("finished reported on an idle tick");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(SLOTS))
    else $error("task count beyond table size");

endmodule

`default_nettype wire

// ===== hw/rtl/preemptive_priority_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Priority scheduler over a table of loaded tasks, one tick per tick word.
// ----------------------------------------------------------------------------
// A word is taken when start is high and busy is low. Load and clear words
// complete in the cycle they are taken and give no result. A tick word picks
// its task through a comparator tree over every slot as it is taken, then
// holds busy through its write-back state; its result word is on out_word with
// out_strobe high for exactly one cycle, the cycle after that, and cannot be
// held off. A new word can be taken in that same cycle, but none while a tick
// is in its write-back state.
`timescale 1ns / 1ps
`default_nettype none

module preemptive_priority_scheduler_core #(
  parameter int SLOTS = psch_pkg::SLOTS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire psch_pkg::in_word_t in_word,
  output logic                    out_strobe,
  output psch_pkg::out_word_t     out_word
);

  psch_pkg::cmd_t  cmd;
  psch_pkg::stat_t stat;

  psch_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_word.mode),
    .stat  (stat),
    .busy  (busy),
    .cmd   (cmd)
  );

  psch_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_word    (in_word),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

endmodule

`default_nettype wire
